// ----- design/aafp_pkg.sv -----
// Shared types, character codes and helpers for the angle field parser.
package aafp_pkg;

    localparam logic [7:0] CH_OPEN  = 8'h28;   // '('
    localparam logic [7:0] CH_CLOSE = 8'h29;   // ')'
    localparam logic [7:0] CH_MINUS = 8'h2D;   // '-'
    localparam logic [7:0] CH_SEMI  = 8'h3B;   // ';'
    localparam logic [7:0] CH_ZERO  = 8'h30;   // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;   // '9'

    localparam logic [31:0] MAG_LIMIT   = 32'h7FFF_FFFF;
    localparam logic [4:0]  INDEX_LIMIT = 5'd31;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_WINDOW = 2'd1;
    localparam logic [1:0] ST_TOO_MANY  = 2'd2;

    typedef enum logic [2:0] {
        PH_BEFORE = 3'b001,
        PH_INSIDE = 3'b010,
        PH_AFTER  = 3'b100
    } phase_t;

    // One queued command: an optional field and an optional end-of-message step.
    typedef struct packed {
        logic        has_field;
        logic [31:0] field_value;
        logic        field_missing;
        logic [4:0]  field_index;
        logic        has_end;
        logic        no_window;
        logic [4:0]  count_after;   // fields emitted once this item's field is out
    } cmd_t;

    function automatic logic [31:0] apply_sign(input logic [31:0] mag, input logic neg);
        apply_sign = neg ? (32'd0 - mag) : mag;
    endfunction

endpackage

// ----- design/axis_angle_field_parser.sv -----
// Top level of the angle field parser: parser, command queue and result expander.
//
//  channel  | dir | tdata (low bit up)                        | tuser             | tlast
//  s_axis   | in  | character[7:0]                            | -                 | end_of_message
//  m_axis   | out | angle_value[31:0], field_index[4:0],      | field_valid,      | last_result
//           |     | status[1:0], 1 zero bit                   | is_missing        |
//
// One character is taken per cycle while the queue has room; the parser decides each combinationally.
// A message end expands into up to NUM_AXES + 1 results, one per cycle from the
// expander, so after it the input waits once the QUEUE_DEPTH-entry queue fills.
// Results pass through one output register; a stalled m_axis holds the expander.
// Reset (rst_n low) clears parse state, queue and output valid; no clearing pass.
module axis_angle_field_parser #(
    parameter int NUM_AXES    = 6,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // character
    input  logic        s_axis_tlast,    // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,    // angle_value, field_index, status, zero pad
    output logic [1:0]  m_axis_tuser,    // field_valid, is_missing
    output logic        m_axis_tlast     // last_result
);
    import aafp_pkg::*;

    cmd_t push_cmd;
    cmd_t head_cmd;
    logic push;
    logic full;
    logic pop;
    logic empty;

    aafp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .cmd           (push_cmd),
        .cmd_push      (push),
        .cmd_full      (full)
    );

    aafp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (empty)
    );

    aafp_back #(
        .NUM_AXES (NUM_AXES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_cmd      (head_cmd),
        .head_empty    (empty),
        .head_pop      (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ----- design/aafp_front.sv -----
// Front end: character parser that turns each item into a queued command.
module aafp_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,
    input  logic          s_axis_tlast,
    output aafp_pkg::cmd_t cmd,
    output logic          cmd_push,
    input  logic          cmd_full
);
    import aafp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [31:0] acc_reg, acc_next;
    logic        neg_reg, neg_next;
    logic        innum_reg, innum_next;
    logic        prev_digit_reg, prev_digit_next;
    logic [4:0]  count_reg, count_next;
    logic        err_reg, err_next;

    logic        accept;
    logic        is_digit;
    logic [34:0] acc_x10;
    logic        opened_last;
    logic        char_field;
    logic        char_missing;
    logic        eom_number;
    logic        emit;

    assign s_axis_tready = !cmd_full;
    assign accept        = s_axis_tvalid && !cmd_full;
    assign is_digit      = (s_axis_tdata >= CH_ZERO) && (s_axis_tdata <= CH_NINE);
    assign acc_x10       = ({3'b000, acc_reg} << 3) + ({3'b000, acc_reg} << 1)
                           + {31'd0, s_axis_tdata[3:0]};

    always_comb
    begin
        phase_next   = phase_reg;
        acc_next     = acc_reg;
        neg_next     = neg_reg;
        innum_next   = innum_reg;
        err_next     = err_reg;
        opened_last  = 1'b0;
        char_field   = 1'b0;
        char_missing = 1'b0;
        eom_number   = 1'b0;

        unique case (phase_reg)
            PH_BEFORE:
            begin
                if (!err_reg) begin
                    if (s_axis_tdata == CH_OPEN) begin
                        phase_next  = PH_INSIDE;
                        opened_last = s_axis_tlast;
                    end else if (s_axis_tdata == CH_CLOSE) begin
                        err_next = 1'b1;
                    end
                end
            end
            PH_INSIDE:
            begin
                if (innum_reg) begin
                    if (is_digit) begin
                        acc_next = (acc_x10 > {3'b000, MAG_LIMIT}) ? MAG_LIMIT
                                                                  : acc_x10[31:0];
                    end else begin
                        // terminator is consumed; ')' still closes the window
                        char_field = 1'b1;
                        innum_next = 1'b0;
                        neg_next   = 1'b0;
                        acc_next   = 32'd0;
                        if (s_axis_tdata == CH_CLOSE)
                            phase_next = PH_AFTER;
                    end
                end else if (is_digit) begin
                    innum_next = 1'b1;
                    neg_next   = 1'b0;
                    acc_next   = {28'd0, s_axis_tdata[3:0]};
                end else if (s_axis_tdata == CH_MINUS) begin
                    innum_next = 1'b1;
                    neg_next   = 1'b1;
                    acc_next   = 32'd0;
                end else if (s_axis_tdata == CH_SEMI) begin
                    if (!prev_digit_reg) begin
                        char_field   = 1'b1;
                        char_missing = 1'b1;
                    end
                end else if (s_axis_tdata == CH_CLOSE) begin
                    phase_next = PH_AFTER;
                end
            end
            PH_AFTER:
            begin
            end
            default:
            begin
                phase_next = PH_BEFORE;
            end
        endcase

        prev_digit_next = is_digit;

        cmd.has_end     = s_axis_tlast;
        cmd.no_window   = (phase_next == PH_BEFORE) || opened_last;
        eom_number      = s_axis_tlast && !cmd.no_window && innum_next;

        emit              = char_field || eom_number;
        cmd.has_field     = emit;
        cmd.field_missing = char_missing;
        cmd.field_index   = count_reg;
        cmd.field_value   = char_missing ? 32'd0
                          : (char_field ? apply_sign(acc_reg, neg_reg)
                                        : apply_sign(acc_next, neg_next));
        count_next        = (emit && (count_reg != INDEX_LIMIT)) ? count_reg + 5'd1
                                                                 : count_reg;
        cmd.count_after   = count_next;

        cmd_push = accept && (emit || s_axis_tlast);

        // end of message returns everything to its reset values
        if (s_axis_tlast) begin
            phase_next      = PH_BEFORE;
            acc_next        = 32'd0;
            neg_next        = 1'b0;
            innum_next      = 1'b0;
            prev_digit_next = 1'b0;
            count_next      = 5'd0;
            err_next        = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg      <= PH_BEFORE;
            acc_reg        <= 32'd0;
            neg_reg        <= 1'b0;
            innum_reg      <= 1'b0;
            prev_digit_reg <= 1'b0;
            count_reg      <= 5'd0;
            err_reg        <= 1'b0;
        end else if (accept) begin
            phase_reg      <= phase_next;
            acc_reg        <= acc_next;
            neg_reg        <= neg_next;
            innum_reg      <= innum_next;
            prev_digit_reg <= prev_digit_next;
            count_reg      <= count_next;
            err_reg        <= err_next;
        end
    end

endmodule

// ----- design/aafp_queue.sv -----
// Small register queue between the parser and the result expander.
module aafp_queue #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  aafp_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output aafp_pkg::cmd_t head_cmd,
    output logic           empty
);
    import aafp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (fill_reg == CNT_W'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        fill_next = fill_reg;
        if (do_push && !do_pop)
            fill_next = fill_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            fill_next = fill_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ----- design/aafp_back.sv -----
// Back end: expands queued commands into result items behind an output register.
module aafp_back #(
    parameter int NUM_AXES = 6
) (
    input  logic           clk,
    input  logic           rst_n,
    input  aafp_pkg::cmd_t head_cmd,
    input  logic           head_empty,
    output logic           head_pop,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [39:0]    m_axis_tdata,   // angle_value, field_index, status, zero pad
    output logic [1:0]     m_axis_tuser,   // field_valid, is_missing
    output logic           m_axis_tlast    // last_result
);
    import aafp_pkg::*;

    localparam int OFF_W = $clog2(NUM_AXES + 1);

    logic             field_done_reg, field_done_next;
    logic [OFF_W-1:0] pad_off_reg, pad_off_next;
    logic             out_valid_reg, out_valid_next;
    logic [39:0]      out_data_reg, out_data_next;
    logic [1:0]       out_user_reg, out_user_next;
    logic             out_last_reg, out_last_next;

    logic             load;
    logic             advance;
    logic [5:0]       pad_sum;
    logic             g_valid_field;
    logic [31:0]      g_value;
    logic             g_missing;
    logic [4:0]       g_index;
    logic [1:0]       g_status;
    logic             g_last;
    logic             g_pop;

    assign load    = !out_valid_reg || m_axis_tready;
    assign advance = load && !head_empty;
    assign pad_sum = 6'(head_cmd.count_after) + 6'(pad_off_reg);

    always_comb
    begin
        g_valid_field   = 1'b0;
        g_value         = 32'd0;
        g_missing       = 1'b0;
        g_index         = 5'd0;
        g_status        = ST_OK;
        g_last          = 1'b0;
        g_pop           = 1'b0;
        field_done_next = field_done_reg;
        pad_off_next    = pad_off_reg;

        if (head_cmd.has_field && !field_done_reg) begin
            g_valid_field   = 1'b1;
            g_value         = head_cmd.field_value;
            g_missing       = head_cmd.field_missing;
            g_index         = head_cmd.field_index;
            g_pop           = !head_cmd.has_end;
            field_done_next = head_cmd.has_end;
        end else if (head_cmd.no_window) begin
            g_status = ST_NO_WINDOW;
            g_last   = 1'b1;
            g_pop    = 1'b1;
        end else if (pad_sum < 6'(NUM_AXES)) begin
            // pad up to the axis count with missing fields
            g_valid_field = 1'b1;
            g_missing     = 1'b1;
            g_index       = pad_sum[4:0];
            pad_off_next  = pad_off_reg + OFF_W'(1);
        end else begin
            g_status = (head_cmd.count_after > 5'(NUM_AXES)) ? ST_TOO_MANY : ST_OK;
            g_last   = 1'b1;
            g_pop    = 1'b1;
        end

        if (g_pop) begin
            field_done_next = 1'b0;
            pad_off_next    = '0;
        end

        head_pop       = advance && g_pop;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;
        if (load) begin
            out_valid_next = !head_empty;
            out_data_next  = {1'b0, g_status, g_index, g_value};
            out_user_next  = {g_missing, g_valid_field};
            out_last_next  = g_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            field_done_reg <= 1'b0;
            pad_off_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (advance) begin
                field_done_reg <= field_done_next;
                pad_off_reg    <= pad_off_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ----- dv/tb_axis_angle_field_parser.sv -----
// Self-checking testbench for the angle field parser: character stream in, field results out.
`timescale 1ns / 1ps

module tb_axis_angle_field_parser;

    import aafp_pkg::*;

    localparam int NUM_AXES    = 6;
    localparam int STALL_LIMIT = 4000;
    localparam int ITEM_GOAL   = 380;

    typedef byte unsigned char_q_t[$];

    typedef struct {
        logic        field_valid;
        logic [31:0] angle_value;
        logic        is_missing;
        logic [4:0]  field_index;
        logic [1:0]  status;
        logic        last_result;
    } angle_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // parser shadow state
    phase_t      pr_phase = PH_BEFORE;
    logic [31:0] pr_mag = '0;
    logic        pr_neg = 1'b0;
    logic        pr_in_num = 1'b0;
    logic        pr_prev_digit = 1'b0;
    logic [4:0]  pr_count = '0;
    logic        pr_win_err = 1'b0;

    angle_result_t expected_angles[$];
    int unsigned   fail_count = 0;
    int unsigned   sent_chars = 0;
    int unsigned   cycle_count = 0;
    int unsigned   quiet_cycles = 0;
    logic          calm = 1'b0;

    axis_angle_field_parser #(.NUM_AXES(NUM_AXES)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // periodic long idle-free stretch (calm), driven from the cycle counter
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        calm <= (cycle_count % 500) >= 330;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 10);
    end

    // ---------------- predictor ----------------

    function automatic void push_angle(input logic [31:0] value, input logic missing);
        angle_result_t r;
        r.field_valid = 1'b1;
        r.angle_value = value;
        r.is_missing  = missing;
        r.field_index = pr_count;
        r.status      = ST_OK;
        r.last_result = 1'b0;
        expected_angles = {expected_angles, r};
        if (pr_count < INDEX_LIMIT)
            pr_count++;
    endfunction

    function automatic void push_status(input logic [1:0] st);
        angle_result_t r;
        r.field_valid = 1'b0;
        r.angle_value = '0;
        r.is_missing  = 1'b0;
        r.field_index = '0;
        r.status      = st;
        r.last_result = 1'b1;
        expected_angles = {expected_angles, r};
    endfunction

    function automatic void flush_number();
        push_angle(pr_neg ? (32'd0 - pr_mag) : pr_mag, 1'b0);
        pr_in_num = 1'b0;
        pr_neg    = 1'b0;
        pr_mag    = '0;
    endfunction

    function automatic void predict_char(input byte unsigned c, input logic eom);
        logic        digit;
        logic        open_last;
        logic [35:0] wide;
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        open_last = 1'b0;
        case (pr_phase)
            PH_BEFORE:
                if (!pr_win_err)
                begin
                    if (c == CH_OPEN)
                    begin
                        pr_phase  = PH_INSIDE;
                        open_last = eom;
                    end
                    else if (c == CH_CLOSE)
                        pr_win_err = 1'b1;
                end
            PH_INSIDE:
            begin
                if (pr_in_num)
                begin
                    if (digit)
                    begin
                        wide = {4'd0, pr_mag} * 36'd10 + {28'd0, c - CH_ZERO};
                        pr_mag = (wide > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : wide[31:0];
                    end
                    else
                    begin
                        // terminator is swallowed, but a ')' still closes
                        flush_number();
                        if (c == CH_CLOSE)
                            pr_phase = PH_AFTER;
                    end
                end
                else if (digit)
                begin
                    pr_in_num = 1'b1;
                    pr_neg    = 1'b0;
                    pr_mag    = {24'd0, c - CH_ZERO};
                end
                else if (c == CH_MINUS)
                begin
                    pr_in_num = 1'b1;
                    pr_neg    = 1'b1;
                    pr_mag    = '0;
                end
                else if (c == CH_SEMI)
                begin
                    if (!pr_prev_digit)
                        push_angle('0, 1'b1);
                end
                else if (c == CH_CLOSE)
                    pr_phase = PH_AFTER;
            end
            default: ;
        endcase
        pr_prev_digit = digit;

        if (eom)
        begin
            if (pr_phase == PH_BEFORE || open_last)
                push_status(ST_NO_WINDOW);
            else
            begin
                if (pr_in_num)
                    flush_number();
                while (pr_count < NUM_AXES)
                    push_angle('0, 1'b1);
                push_status((pr_count > NUM_AXES) ? ST_TOO_MANY : ST_OK);
            end
            pr_phase      = PH_BEFORE;
            pr_mag        = '0;
            pr_neg        = 1'b0;
            pr_in_num     = 1'b0;
            pr_prev_digit = 1'b0;
            pr_count      = '0;
            pr_win_err    = 1'b0;
        end
    endfunction

    // ---------------- result checking ----------------

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        angle_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_angles.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual tdata=%h tuser=%b tlast=%b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                fail_count++;
            end
            else
            begin
                want = expected_angles.pop_front();
                check_field("field_valid", 32'(want.field_valid), 32'(m_axis_tuser[0]));
                check_field("angle_value", want.angle_value, m_axis_tdata[31:0]);
                check_field("is_missing", 32'(want.is_missing), 32'(m_axis_tuser[1]));
                check_field("field_index", 32'(want.field_index), 32'(m_axis_tdata[36:32]));
                check_field("status", 32'(want.status), 32'(m_axis_tdata[38:37]));
                check_field("last_result", 32'(want.last_result), 32'(m_axis_tlast));
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ---------------- stimulus ----------------

    task automatic send_char(input byte unsigned c, input logic eom);
        while (!calm && $urandom_range(0, 99) < 10)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= eom;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent_chars++;
        predict_char(c, eom);
    endtask

    task automatic send_message(input char_q_t msg);
        foreach (msg[i])
            send_char(msg[i], i == msg.size() - 1);
    endtask

    task automatic send_text(input string s);
        char_q_t msg;
        for (int i = 0; i < s.len(); i++)
            msg = {msg, 8'(s[i])};
        send_message(msg);
    endtask

    function automatic byte unsigned junk_char();
        byte unsigned b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_OPEN || b == CH_CLOSE);
        return b;
    endfunction

    function automatic byte unsigned noise_char();
        case ($urandom_range(0, 5))
            0: return CH_OPEN;
            1: return CH_CLOSE;
            2: return CH_SEMI;
            3: return CH_MINUS;
            4: return 8'(CH_ZERO + $urandom_range(0, 9));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // prefix, '(', fields with random content, optional close and tail
    function automatic char_q_t make_command(input int nfields);
        char_q_t msg;
        int      ndig;
        int      pick;
        repeat ($urandom_range(0, 3))
            msg = {msg, junk_char()};
        msg = {msg, CH_OPEN};
        for (int f = 0; f < nfields; f++)
        begin
            pick = int'($urandom_range(0, 99));
            if (pick < 15)
                ;   // empty field
            else if (pick < 25)
                msg = {msg, CH_MINUS};
            else
            begin
                if ($urandom_range(0, 1))
                    msg = {msg, CH_MINUS};
                ndig = ($urandom_range(0, 9) == 0) ? int'($urandom_range(9, 12))
                                                   : int'($urandom_range(1, 4));
                repeat (ndig)
                    msg = {msg, 8'(CH_ZERO + $urandom_range(0, 9))};
            end
            if (f < nfields - 1)
                msg = {msg, (($urandom_range(0, 99) < 85) ? CH_SEMI : junk_char())};
        end
        pick = int'($urandom_range(0, 99));
        if (pick < 75)
        begin
            msg = {msg, CH_CLOSE};
            repeat ($urandom_range(0, 3))
                msg = {msg, 8'($urandom_range(0, 255))};
        end
        else if (pick < 85)
            msg = {msg, CH_SEMI};
        return msg;
    endfunction

    task automatic test_window_rules();
        char_q_t msg;
        send_text("()");
        send_text(")(1)");
        send_text("a(");
        msg = '{8'h00, 8'hFF};
        send_message(msg);
    endtask

    task automatic test_number_rules();
        send_text("(-)");
        send_text("(-");
        send_text("(;7");
        send_text("(-9999999999)");
        send_text("(;;;;;;;)");
    endtask

    task automatic test_index_saturation();
        char_q_t msg;
        msg = {msg, CH_OPEN};
        repeat (34)
        begin
            msg = {msg, 8'(CH_ZERO + $urandom_range(0, 9))};
            msg = {msg, CH_SEMI};
        end
        msg = {msg, CH_CLOSE};
        send_message(msg);
    endtask

    task automatic test_random_messages();
        char_q_t msg;
        while (sent_chars < ITEM_GOAL)
        begin
            msg = {};
            if ($urandom_range(0, 99) < 80)
                msg = make_command(($urandom_range(0, 9) == 0) ? int'($urandom_range(7, 12))
                                                               : int'($urandom_range(0, 7)));
            else
                repeat ($urandom_range(1, 10))
                    msg = {msg, noise_char()};
            send_message(msg);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_window_rules();
        test_number_rules();
        test_index_saturation();
        test_random_messages();
        s_axis_tvalid <= 1'b0;
        while (expected_angles.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- sim.f -----
design/aafp_pkg.sv
design/aafp_front.sv
design/aafp_queue.sv
design/aafp_back.sv
design/axis_angle_field_parser.sv
dv/tb_axis_angle_field_parser.sv
